[rtl/tlbcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbcr_pkg
// Shared types and constants for the clock-replacement TLB and its cells.
// ----------------------------------------------------------------------------
package tlbcr_pkg;

	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// flags carried by the lookup item as it walks the cell chain
	typedef struct packed {
		logic tok;
		logic hit;
		logic inv_found;
		logic use_found;
	} walk_flg_t;

	// update broadcast to all cells when a lookup retires
	typedef struct packed {
		logic commit;
		logic fill;
		logic wr;
		logic clr_en;
	} commit_t;

endpackage

[rtl/tlb_lookup_clock_replace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lookup_clock_replace
// Fully associative TLB with second-chance replacement, built as a chain of
// entry cells that a lookup walks one cell per clock.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. It walks the entry
// chain one cell per clock over the entries in use until the table is updated
// and busy drops; the result is shown on frame, hit, entry_index and
// mark_page_dirty for the single cycle in which done is high, the cycle after the
// update. The receiver cannot stall: a result not taken in that cycle is gone.
// A new access may be started in the same cycle that done is high.
// entries_in_use is written through cfg_valid/cfg_data while no access is in
// flight; 0 acts as 1 and values above TLB_DEPTH act as TLB_DEPTH.
module tlb_lookup_clock_replace #(
	parameter int TLB_DEPTH  = 16,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [PAGE_BITS-1:0]          virtual_page,
	input  logic                          is_write,
	input  logic [FRAME_BITS-1:0]         table_frame,
	output logic                          done,
	output logic [FRAME_BITS-1:0]         frame,
	output logic                          hit,
	output logic [$clog2(TLB_DEPTH)-1:0]  entry_index,
	output logic                          mark_page_dirty,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tlbcr_pkg::CFG_W-1:0]   cfg_data
);

	localparam int IW = $clog2(TLB_DEPTH);
	localparam int CW = $clog2(TLB_DEPTH + 1);

	logic [tlbcr_pkg::CFG_W-1:0] cfg_q;
	logic [CW-1:0]               cnt_cfg;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        tok0_q;
	logic [PAGE_BITS-1:0]        page_q;
	logic                        wr_q;
	logic [FRAME_BITS-1:0]       tframe_q;
	logic                        accept;

	tlbcr_pkg::walk_flg_t        flg     [0:TLB_DEPTH];
	logic [IW-1:0]               hit_idx [0:TLB_DEPTH];
	logic [FRAME_BITS-1:0]       frm     [0:TLB_DEPTH];
	logic [IW-1:0]               inv_idx [0:TLB_DEPTH];
	logic [IW-1:0]               use_idx [0:TLB_DEPTH];

	tlbcr_pkg::walk_flg_t        end_flg;
	logic [IW-1:0]               end_hit_idx;
	logic [FRAME_BITS-1:0]       end_frame;
	logic [IW-1:0]               end_inv_idx;
	logic [IW-1:0]               end_use_idx;

	tlbcr_pkg::commit_t          cmd;
	logic [IW-1:0]               cmd_idx;
	logic [CW-1:0]               cmd_lim;
	logic [FRAME_BITS-1:0]       res_frame;

	logic                        done_q;
	logic [FRAME_BITS-1:0]       frame_q;
	logic                        hit_q;
	logic [IW-1:0]               idx_q;
	logic                        dirty_q;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;

	always_comb begin
		if (cfg_q == '0) begin
			cnt_cfg = CW'(1);
		end else if (int'(cfg_q) > TLB_DEPTH) begin
			cnt_cfg = CW'(TLB_DEPTH);
		end else begin
			cnt_cfg = CW'(cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= tlbcr_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tok0_q <= 1'b0;
			cnt_q  <= CW'(TLB_DEPTH);
		end else begin
			tok0_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= cnt_cfg;
			end else if (cmd.commit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q   <= virtual_page;
			wr_q     <= is_write;
			tframe_q <= table_frame;
		end
	end

	// head of the chain
	always_comb begin
		flg[0]     = '0;
		flg[0].tok = tok0_q;
		hit_idx[0] = '0;
		frm[0]     = '0;
		inv_idx[0] = '0;
		use_idx[0] = '0;
	end

	for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
		tlbcr_cell #(
			.IDX        (g),
			.PAGE_BITS  (PAGE_BITS),
			.FRAME_BITS (FRAME_BITS),
			.IW         (IW),
			.CW         (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cnt         (cnt_q),
			.req_page    (page_q),
			.flg_in      (flg[g]),
			.hit_idx_in  (hit_idx[g]),
			.frame_in    (frm[g]),
			.inv_idx_in  (inv_idx[g]),
			.use_idx_in  (use_idx[g]),
			.flg_out     (flg[g+1]),
			.hit_idx_out (hit_idx[g+1]),
			.frame_out   (frm[g+1]),
			.inv_idx_out (inv_idx[g+1]),
			.use_idx_out (use_idx[g+1]),
			.cmd         (cmd),
			.cmd_idx     (cmd_idx),
			.cmd_lim     (cmd_lim),
			.fill_page   (page_q),
			.fill_frame  (tframe_q)
		);
	end

	// tap the output of the last cell in use
	always_comb begin
		end_flg     = '0;
		end_hit_idx = '0;
		end_frame   = '0;
		end_inv_idx = '0;
		end_use_idx = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			if (cnt_q == CW'(i + 1)) begin
				end_flg     = flg[i+1];
				end_hit_idx = hit_idx[i+1];
				end_frame   = frm[i+1];
				end_inv_idx = inv_idx[i+1];
				end_use_idx = use_idx[i+1];
			end
		end
	end

	// victim choice and table update
	always_comb begin
		cmd        = '0;
		cmd.commit = end_flg.tok && busy_q;
		cmd.wr     = wr_q;
		cmd_idx    = '0;
		cmd_lim    = '0;
		res_frame  = tframe_q;
		if (end_flg.hit) begin
			cmd_idx   = end_hit_idx;
			res_frame = end_frame;
		end else if (end_flg.inv_found) begin
			cmd.fill = 1'b1;
			cmd_idx  = end_inv_idx;
		end else if (end_flg.use_found) begin
			cmd.fill   = 1'b1;
			cmd.clr_en = 1'b1;
			cmd_idx    = end_use_idx;
			cmd_lim    = CW'(end_use_idx);
		end else begin
			cmd.fill   = 1'b1;
			cmd.clr_en = 1'b1;
			cmd_lim    = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			frame_q <= res_frame;
			hit_q   <= end_flg.hit;
			idx_q   <= cmd_idx;
			dirty_q <= wr_q;
		end
	end

	assign done            = done_q;
	assign frame           = frame_q;
	assign hit             = hit_q;
	assign entry_index     = idx_q;
	assign mark_page_dirty = dirty_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result shown while an access is still walking");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted access did not raise busy");

	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result without an access in flight");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (CW'(idx_q) < cnt_q))
		else $error("entry index beyond entries in use");
`endif

endmodule

[rtl/tlbcr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbcr_cell
// One TLB entry: holds page, frame and valid/used/dirty marks, checks the
// walking lookup against its entry and hands the result to the next cell.
// ----------------------------------------------------------------------------
module tlbcr_cell #(
	parameter int IDX        = 0,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20,
	parameter int IW         = 4,
	parameter int CW         = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CW-1:0]         cnt,
	input  logic [PAGE_BITS-1:0]  req_page,
	input  tlbcr_pkg::walk_flg_t  flg_in,
	input  logic [IW-1:0]         hit_idx_in,
	input  logic [FRAME_BITS-1:0] frame_in,
	input  logic [IW-1:0]         inv_idx_in,
	input  logic [IW-1:0]         use_idx_in,
	output tlbcr_pkg::walk_flg_t  flg_out,
	output logic [IW-1:0]         hit_idx_out,
	output logic [FRAME_BITS-1:0] frame_out,
	output logic [IW-1:0]         inv_idx_out,
	output logic [IW-1:0]         use_idx_out,
	input  tlbcr_pkg::commit_t    cmd,
	input  logic [IW-1:0]         cmd_idx,
	input  logic [CW-1:0]         cmd_lim,
	input  logic [PAGE_BITS-1:0]  fill_page,
	input  logic [FRAME_BITS-1:0] fill_frame
);

	logic                  valid_q;
	logic                  used_q;
	logic                  dirty_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_q;
	tlbcr_pkg::walk_flg_t  flg_q;
	logic [IW-1:0]         hit_idx_q;
	logic [FRAME_BITS-1:0] frm_q;
	logic [IW-1:0]         inv_idx_q;
	logic [IW-1:0]         use_idx_q;

	logic active;
	logic match;
	logic take_inv;
	logic take_use;
	logic me;

	assign active   = (CW'(IDX) < cnt);
	assign match    = flg_in.tok && active && valid_q && (page_q == req_page);
	assign take_inv = flg_in.tok && active && !valid_q && !flg_in.inv_found;
	assign take_use = flg_in.tok && active && !used_q && !flg_in.use_found;
	assign me       = (cmd_idx == IW'(IDX));

	// the token stops at the first cell beyond the entries in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_q <= '0;
		end else begin
			flg_q.tok       <= flg_in.tok && active;
			flg_q.hit       <= flg_in.hit | match;
			flg_q.inv_found <= flg_in.inv_found | take_inv;
			flg_q.use_found <= flg_in.use_found | take_use;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q <= match ? IW'(IDX) : hit_idx_in;
		frm_q     <= match ? frame_q : frame_in;
		inv_idx_q <= take_inv ? IW'(IDX) : inv_idx_in;
		use_idx_q <= take_use ? IW'(IDX) : use_idx_in;
	end

	// entry marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q  <= 1'b0;
			dirty_q <= 1'b0;
		end else if (cmd.commit) begin
			if (me) begin
				used_q <= 1'b1;
				if (cmd.fill) begin
					valid_q <= 1'b1;
					dirty_q <= cmd.wr;
				end else if (cmd.wr) begin
					dirty_q <= 1'b1;
				end
			end else if (cmd.clr_en && (CW'(IDX) < cmd_lim)) begin
				used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.fill && me) begin
			page_q  <= fill_page;
			frame_q <= fill_frame;
		end
	end

	assign flg_out     = flg_q;
	assign hit_idx_out = hit_idx_q;
	assign frame_out   = frm_q;
	assign inv_idx_out = inv_idx_q;
	assign use_idx_out = use_idx_q;

endmodule

[dv/tlb_lookup_clock_replace_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lookup_clock_replace_tb
// Self-checking bench for the clock-replacement TLB. A driver feeds accesses
// and table-size writes from a queue, a built-in TLB model predicts frame,
// hit, entry and dirty flag for every accepted access, and a monitor checks
// each done strobe against the oldest prediction. Directed cases cover fills,
// hits, the used-mark sweep, duplicate pages and out-of-range sizes; random
// phases then mix reused pages with fresh ones under each table size.
// ----------------------------------------------------------------------------
module tlb_lookup_clock_replace_tb;

	localparam int DEPTH  = 16;
	localparam int PG_W   = 20;
	localparam int FR_W   = 20;
	localparam int IDX_W  = 4;
	localparam int POOL_N = DEPTH + 3;
	localparam int N_PHASE = 11;
	localparam int PHASE_ITEMS = 55;

	typedef enum bit {ITEM_ACCESS, ITEM_CFG} item_kind_t;

	typedef struct {
		item_kind_t                kind;
		bit [PG_W-1:0]             page;
		bit                        wr;
		bit [FR_W-1:0]             tframe;
		bit [tlbcr_pkg::CFG_W-1:0] cfg_val;
		int                        gap;
	} tlb_item_t;

	typedef struct {
		bit [FR_W-1:0]  frame;
		bit             hit;
		bit [IDX_W-1:0] entry_index;
		bit             mark_page_dirty;
	} tlb_answer_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [PG_W-1:0]               virtual_page = '0;
	logic                          is_write = 1'b0;
	logic [FR_W-1:0]               table_frame = '0;
	logic                          done;
	logic [FR_W-1:0]               frame;
	logic                          hit;
	logic [IDX_W-1:0]              entry_index;
	logic                          mark_page_dirty;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tlbcr_pkg::CFG_W-1:0]   cfg_data = '0;

	// tlb model state
	bit [tlbcr_pkg::CFG_W-1:0] m_entries;
	bit             m_valid [DEPTH];
	bit             m_used  [DEPTH];
	bit             m_dirty [DEPTH];
	bit [PG_W-1:0]  m_page  [DEPTH];
	bit [FR_W-1:0]  m_frame [DEPTH];

	tlb_item_t   access_q [$];
	tlb_answer_t tlb_answers_q [$];
	tlb_item_t   cur;
	bit          have_cur = 1'b0;
	int          gap_left = 0;
	int          mismatch_cnt = 0;
	int          n_access = 0;
	int          n_hit = 0;
	int          n_cfg = 0;

	tlb_lookup_clock_replace dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.virtual_page    (virtual_page),
		.is_write        (is_write),
		.table_frame     (table_frame),
		.done            (done),
		.frame           (frame),
		.hit             (hit),
		.entry_index     (entry_index),
		.mark_page_dirty (mark_page_dirty),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic tlb_answer_t tlb_lookup_predict(bit [PG_W-1:0] pg, bit wr,
			bit [FR_W-1:0] tf);
		tlb_answer_t r;
		int          n;
		int          idx;
		int          i;
		bit          found;
		bit          picked;
		n = (m_entries == 0) ? 1 : ((m_entries > DEPTH) ? DEPTH : int'(m_entries));
		found = 1'b0;
		idx = 0;
		for (i = 0; i < n; i++)
			if (m_valid[i] && m_page[i] == pg) begin
				found = 1'b1;
				idx = i;
			end
		if (found) begin
			r.frame = m_frame[idx];
		end else begin
			r.frame = tf;
			picked = 1'b0;
			for (i = 0; i < n && !picked; i++)
				if (!m_valid[i]) begin
					idx = i;
					picked = 1'b1;
				end
			// second chance sweep, falls back to entry 0
			if (!picked) begin
				idx = 0;
				for (i = 0; i < n && !picked; i++)
					if (!m_used[i]) begin
						idx = i;
						picked = 1'b1;
					end else begin
						m_used[i] = 1'b0;
					end
			end
			m_page[idx] = pg;
			m_frame[idx] = tf;
			m_valid[idx] = 1'b1;
			m_dirty[idx] = 1'b0;
		end
		m_used[idx] = 1'b1;
		if (wr)
			m_dirty[idx] = 1'b1;
		r.hit = found;
		r.entry_index = idx[IDX_W-1:0];
		r.mark_page_dirty = wr;
		return r;
	endfunction

	task automatic push_access(bit [PG_W-1:0] pg, bit wr, bit [FR_W-1:0] tf, int gap);
		tlb_item_t it;
		it.kind = ITEM_ACCESS;
		it.page = pg;
		it.wr = wr;
		it.tframe = tf;
		it.cfg_val = '0;
		it.gap = gap;
		access_q.push_back(it);
	endtask

	task automatic push_cfg(bit [tlbcr_pkg::CFG_W-1:0] val);
		tlb_item_t it;
		it.kind = ITEM_CFG;
		it.page = '0;
		it.wr = 1'b0;
		it.tframe = '0;
		it.cfg_val = val;
		it.gap = 0;
		access_q.push_back(it);
	endtask

	// driver
	always @(posedge clk) begin : driver
		logic        next_start;
		logic        next_cfg;
		tlb_answer_t got;
		if (arst_n) begin
			next_start = start;
			next_cfg = cfg_valid;
			if (start && !busy) begin
				got = tlb_lookup_predict(virtual_page, is_write, table_frame);
				tlb_answers_q.push_back(got);
				n_access++;
				if (got.hit)
					n_hit++;
				next_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				m_entries = cfg_data;
				n_cfg++;
				next_cfg = 1'b0;
			end
			if (!next_start && !next_cfg) begin
				if (!have_cur && access_q.size() != 0) begin
					cur = access_q.pop_front();
					have_cur = 1'b1;
					gap_left = cur.gap;
				end
				if (have_cur) begin
					if (gap_left > 0) begin
						gap_left--;
					end else if (cur.kind == ITEM_ACCESS) begin
						virtual_page <= cur.page;
						is_write <= cur.wr;
						table_frame <= cur.tframe;
						next_start = 1'b1;
						have_cur = 1'b0;
					end else if (tlb_answers_q.size() == 0 && !busy) begin
						cfg_data <= cur.cfg_val;
						next_cfg = 1'b1;
						have_cur = 1'b0;
					end
				end
			end
			start <= next_start;
			cfg_valid <= next_cfg;
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		tlb_answer_t want;
		if (arst_n && done) begin
			if (tlb_answers_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result with no access pending: frame=%h hit=%b idx=%0d dirty=%b",
						$realtime, frame, hit, entry_index, mark_page_dirty);
			end else begin
				want = tlb_answers_q.pop_front();
				if (frame !== want.frame || hit !== want.hit ||
						entry_index !== want.entry_index ||
						mark_page_dirty !== want.mark_page_dirty) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("%0t: mismatch exp frame=%h hit=%b idx=%0d dirty=%b",
							$realtime, want.frame, want.hit, want.entry_index,
							want.mark_page_dirty);
						$display("%0t:          got frame=%h hit=%b idx=%0d dirty=%b",
							$realtime, frame, hit, entry_index, mark_page_dirty);
					end
				end
			end
		end
	end

	initial begin : limit
		#1000000;
		$display("tlb_lookup_clock_replace_tb: done, errors");
		$finish;
	end

	initial begin : main
		bit [PG_W-1:0]             pool [POOL_N];
		bit [tlbcr_pkg::CFG_W-1:0] phase_sizes [N_PHASE];
		int                        ph;
		int                        k;
		int                        n;
		int                        eff;
		int                        gap;
		bit [PG_W-1:0]             pg;

		m_entries = tlbcr_pkg::CFG_RESET;
		for (k = 0; k < DEPTH; k++) begin
			m_valid[k] = 1'b0;
			m_used[k] = 1'b0;
			m_dirty[k] = 1'b0;
			m_page[k] = '0;
			m_frame[k] = '0;
		end

		// fills, hits, writes
		push_cfg(5'd16);
		push_access(20'h00000, 1'b0, 20'h00000, 0);
		push_access(20'hFFFFF, 1'b1, 20'hFFFFF, 0);
		push_access(20'hAAAAA, 1'b0, 20'h55555, 2);
		push_access(20'h55555, 1'b1, 20'hAAAAA, 0);
		push_access(20'h00000, 1'b1, 20'h12345, 0);
		push_access(20'hFFFFF, 1'b0, 20'h00000, 1);
		// small table: sweep clears marks, then stops at a clear one
		push_cfg(5'd2);
		push_access(20'h55555, 1'b0, 20'h0F0F0, 0);
		push_access(20'h33333, 1'b1, 20'hF0F0F, 0);
		// page now in two entries, the higher one wins
		push_cfg(5'd16);
		push_access(20'h55555, 1'b1, 20'h00000, 0);
		// single entry and zero size
		push_cfg(5'd1);
		push_access(20'h77777, 1'b0, 20'h11111, 0);
		push_access(20'h77777, 1'b1, 20'h22222, 3);
		push_access(20'h88888, 1'b0, 20'h33333, 0);
		push_cfg(5'd0);
		push_access(20'h99999, 1'b1, 20'h44444, 0);
		push_access(20'h99999, 1'b0, 20'h66666, 0);
		// size above depth
		push_cfg(5'd31);
		push_access(20'hAAAAA, 1'b0, 20'h00001, 0);
		push_access(20'hFFFFF, 1'b1, 20'h80000, 0);

		for (k = 0; k < POOL_N; k++)
			pool[k] = PG_W'($urandom);
		phase_sizes = '{5'd16, 5'd4, 5'd1, 5'd8, 5'd17, 5'd2, 5'd15, 5'd0, 5'd31,
			5'd5, 5'd16};
		n = 0;
		for (ph = 0; ph < N_PHASE; ph++) begin
			push_cfg(phase_sizes[ph]);
			eff = (phase_sizes[ph] == 0) ? 1 :
				((phase_sizes[ph] > DEPTH) ? DEPTH : int'(phase_sizes[ph]));
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (n >= 500 || (n / 40) % 3 == 2)
					gap = 0;
				else if ($urandom_range(99) < 35)
					gap = $urandom_range(12, 1);
				else
					gap = 0;
				if ($urandom_range(99) < 85)
					pg = pool[$urandom_range(eff + 2)];
				else
					pg = PG_W'($urandom);
				push_access(pg, 1'($urandom_range(1)), FR_W'($urandom), gap);
				n++;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (access_q.size() != 0 || have_cur || start || cfg_valid)
			@(posedge clk);
		while (tlb_answers_q.size() != 0)
			@(posedge clk);
		repeat (3 * DEPTH) @(posedge clk);

		$display("ran %0d accesses (%0d hits, %0d fills) over %0d table-size writes",
			n_access, n_hit, n_access - n_hit, n_cfg);
		$display("table sizes included zero, one, full depth and above depth; %0d mismatches",
			mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("tlb_lookup_clock_replace_tb: done, clean");
		else
			$display("tlb_lookup_clock_replace_tb: done, errors");
		$finish;
	end

endmodule
